[rtl/llex_pkg.sv]
// Shared types and constants of the logic language lexer.
// Holds the request and result structs and the token kind codes.
// Used by logic_language_lexer_top.
package llex_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned OFFSET_W = 24;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned LINE_W   = 16;
    localparam int unsigned COLUMN_W = 16;
    localparam int unsigned ARG_W    = 32;

    typedef enum logic [3:0] {
        K_ADD    = 4'd0,
        K_MUL    = 4'd1,
        K_LPAREN = 4'd2,
        K_RPAREN = 4'd3,
        K_COMMA  = 4'd4,
        K_DOT    = 4'd5,
        K_EQUAL  = 4'd6,
        K_LIMPLY = 4'd7,
        K_IS     = 4'd8,
        K_VAR    = 4'd9,
        K_ATOM   = 4'd10,
        K_INT    = 4'd11,
        K_END    = 4'd12,
        K_ERR    = 4'd13
    } kind_t;

    localparam logic [CH_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CH_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CH_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CH_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CH_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [CH_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CH_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CH_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CH_W-1:0] CH_EQUAL      = 8'h3D;
    localparam logic [CH_W-1:0] CH_LESS       = 8'h3C;
    localparam logic [CH_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CH_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [CH_W-1:0] CH_DIGIT_9    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CH_W-1:0] CH_LOWER_I    = 8'h69;
    localparam logic [CH_W-1:0] CH_LOWER_S    = 8'h73;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            end_req;
    } src_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [OFFSET_W-1:0] start_offset;
        logic [LENGTH_W-1:0] length;
        logic [LINE_W-1:0]   line;
        logic [COLUMN_W-1:0] column;
        logic                last;
    } tok_item_t;

endpackage

[rtl/logic_language_lexer_top.sv]
// Top level of the logic language lexer: byte scanner and result queue.
// Depends on llex_pkg for the request/result structs and token kinds.
//
// One source byte is taken per cycle. Each byte is classified and the scan
// state updated in the same cycle; the zero, one or two tokens it closes are
// written into a four-entry result queue that drains one token per cycle unless tok_stall.
// src_stall rises while the queue holds more than two tokens, so the byte rate
// is one per cycle except where bytes that close two tokens at once outpace the
// single-token output port, or the receiver stalls. A token leaves the queue
// the cycle after its byte is taken at the earliest.
module logic_language_lexer_top #(
    parameter int unsigned OFFSET_BITS = 24,
    parameter int unsigned LINE_BITS   = 16,
    parameter int unsigned COLUMN_BITS = 16,
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  llex_pkg::src_item_t   src_data,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output llex_pkg::tok_item_t   tok_data
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_INT     = 3'd1,
        M_VAR     = 3'd2,
        M_ATOM    = 3'd3,
        M_LT      = 3'd4,
        M_SLASH   = 3'd5,
        M_COMMENT = 3'd6,
        M_ERROR   = 3'd7
    } mode_t;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KP_NONE = 2'd0;
    localparam logic [1:0] KP_I    = 2'd1;
    localparam logic [1:0] KP_IS   = 2'd2;
    localparam logic [1:0] KP_NO   = 2'd3;

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] cur_offset_reg, cur_offset_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_column_reg, cur_column_next;
    logic [OFFSET_BITS-1:0] tok_offset_reg, tok_offset_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_column_reg, tok_column_next;
    logic [LENGTH_BITS-1:0] tok_length_reg, tok_length_next;
    logic [1:0]             kp_reg, kp_next;

    llex_pkg::tok_item_t    q_reg [QDEPTH];
    logic [QPTR_W-1:0]      head_reg, head_next;
    logic [QPTR_W-1:0]      tail_reg, tail_next;
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;

    logic                   take;
    logic                   pop;
    logic [7:0]             c;
    logic                   is_space, is_digit, is_upper, is_lower, is_ident;
    logic [OFFSET_BITS-1:0] adv_offset;
    logic [LINE_BITS-1:0]   adv_line;
    logic [COLUMN_BITS-1:0] adv_column;
    logic [LENGTH_BITS-1:0] len_inc;
    logic                   do_advance;
    logic                   do_fresh;
    logic                   pend_vld, fresh_vld;
    llex_pkg::tok_item_t    pend_res, fresh_res;
    llex_pkg::tok_item_t    r0, r1;
    logic [1:0]             n_push;
    llex_pkg::kind_t        pend_kind;

    function automatic llex_pkg::tok_item_t mk_tok(
        input llex_pkg::kind_t            k,
        input logic [llex_pkg::ARG_W-1:0] off,
        input logic [llex_pkg::ARG_W-1:0] len,
        input logic [llex_pkg::ARG_W-1:0] ln,
        input logic [llex_pkg::ARG_W-1:0] col
    );
        llex_pkg::tok_item_t t;
        t.kind         = k;
        t.start_offset = (|off[llex_pkg::ARG_W-1:llex_pkg::OFFSET_W]) ? '1
                         : off[llex_pkg::OFFSET_W-1:0];
        t.length       = (|len[llex_pkg::ARG_W-1:llex_pkg::LENGTH_W]) ? '1
                         : len[llex_pkg::LENGTH_W-1:0];
        t.line         = (|ln[llex_pkg::ARG_W-1:llex_pkg::LINE_W]) ? '1
                         : ln[llex_pkg::LINE_W-1:0];
        t.column       = (|col[llex_pkg::ARG_W-1:llex_pkg::COLUMN_W]) ? '1
                         : col[llex_pkg::COLUMN_W-1:0];
        t.last         = 1'b0;
        return t;
    endfunction

    assign take      = src_valid && !src_stall;
    assign src_stall = (cnt_reg > QCNT_W'(2));
    assign tok_valid = (cnt_reg != '0);
    assign tok_data  = q_reg[head_reg];
    assign pop       = tok_valid && !tok_stall;

    assign c        = src_data.ch;
    assign is_space = (c == llex_pkg::CH_SPACE)
                      || ((c >= llex_pkg::CH_TAB) && (c <= llex_pkg::CH_CR));
    assign is_digit = (c >= llex_pkg::CH_DIGIT_0) && (c <= llex_pkg::CH_DIGIT_9);
    assign is_upper = (c >= llex_pkg::CH_UPPER_A) && (c <= llex_pkg::CH_UPPER_Z);
    assign is_lower = (c >= llex_pkg::CH_LOWER_A) && (c <= llex_pkg::CH_LOWER_Z);
    assign is_ident = is_digit || is_upper || is_lower || (c == llex_pkg::CH_UNDERSCORE);

    assign adv_offset = (&cur_offset_reg) ? cur_offset_reg
                        : cur_offset_reg + OFFSET_BITS'(1);
    assign adv_line   = (c != llex_pkg::CH_NEWLINE) ? cur_line_reg
                        : ((&cur_line_reg) ? cur_line_reg : cur_line_reg + LINE_BITS'(1));
    assign adv_column = (c == llex_pkg::CH_NEWLINE) ? COLUMN_BITS'(1)
                        : ((&cur_column_reg) ? cur_column_reg
                           : cur_column_reg + COLUMN_BITS'(1));
    assign len_inc    = (&tok_length_reg) ? tok_length_reg
                        : tok_length_reg + LENGTH_BITS'(1);

    always_comb
    begin
        case (mode_reg)
            M_INT:   pend_kind = llex_pkg::K_INT;
            M_VAR:   pend_kind = llex_pkg::K_VAR;
            default: pend_kind = (kp_reg == KP_IS) ? llex_pkg::K_IS : llex_pkg::K_ATOM;
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        tok_offset_next = tok_offset_reg;
        tok_line_next   = tok_line_reg;
        tok_column_next = tok_column_reg;
        tok_length_next = tok_length_reg;
        kp_next         = kp_reg;
        do_advance      = 1'b0;
        do_fresh        = 1'b0;
        pend_vld        = 1'b0;
        fresh_vld       = 1'b0;
        pend_res        = mk_tok(pend_kind, 32'(tok_offset_reg), 32'(tok_length_reg),
                                 32'(tok_line_reg), 32'(tok_column_reg));
        fresh_res       = mk_tok(llex_pkg::K_ERR, 32'(cur_offset_reg), 32'd0,
                                 32'(cur_line_reg), 32'(cur_column_reg));

        if (src_data.end_req)
        begin
            case (mode_reg)
                M_INT, M_VAR, M_ATOM:
                begin
                    pend_vld = 1'b1;
                end
                M_LT, M_SLASH:
                begin
                    pend_vld = 1'b1;
                    pend_res = mk_tok(llex_pkg::K_ERR, 32'(tok_offset_reg), 32'd0,
                                      32'(tok_line_reg), 32'(tok_column_reg));
                end
                default:
                begin
                    pend_vld = 1'b0;
                end
            endcase
            fresh_vld      = 1'b1;
            fresh_res.kind = llex_pkg::K_END;
        end
        else
        begin
            case (mode_reg)
                M_ERROR:
                begin
                    mode_next = M_ERROR;
                end
                M_COMMENT:
                begin
                    if (c == llex_pkg::CH_NEWLINE)
                    begin
                        mode_next = M_IDLE;
                    end
                    do_advance = 1'b1;
                end
                M_INT:
                begin
                    if (is_digit)
                    begin
                        tok_length_next = len_inc;
                        do_advance      = 1'b1;
                    end
                    else
                    begin
                        pend_vld = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                M_VAR, M_ATOM:
                begin
                    if (is_ident)
                    begin
                        kp_next         = ((kp_reg == KP_I) && (c == llex_pkg::CH_LOWER_S))
                                          ? KP_IS : KP_NO;
                        tok_length_next = len_inc;
                        do_advance      = 1'b1;
                    end
                    else
                    begin
                        pend_vld = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                M_LT:
                begin
                    pend_vld = 1'b1;
                    if (c == llex_pkg::CH_EQUAL)
                    begin
                        pend_res   = mk_tok(llex_pkg::K_LIMPLY, 32'(tok_offset_reg), 32'd2,
                                            32'(tok_line_reg), 32'(tok_column_reg));
                        do_advance = 1'b1;
                        mode_next  = M_IDLE;
                    end
                    else
                    begin
                        pend_res  = mk_tok(llex_pkg::K_ERR, 32'(tok_offset_reg), 32'd0,
                                           32'(tok_line_reg), 32'(tok_column_reg));
                        mode_next = M_ERROR;
                    end
                end
                M_SLASH:
                begin
                    if (c == llex_pkg::CH_SLASH)
                    begin
                        mode_next  = M_COMMENT;
                        do_advance = 1'b1;
                    end
                    else
                    begin
                        pend_vld  = 1'b1;
                        pend_res  = mk_tok(llex_pkg::K_ERR, 32'(tok_offset_reg), 32'd0,
                                           32'(tok_line_reg), 32'(tok_column_reg));
                        mode_next = M_ERROR;
                    end
                end
                default:
                begin
                    do_fresh = 1'b1;
                end
            endcase

            if (do_fresh)
            begin
                mode_next  = M_IDLE;
                do_advance = 1'b1;
                if (is_space)
                begin
                    mode_next = M_IDLE;
                end
                else if (is_digit || is_upper || is_lower
                         || (c == llex_pkg::CH_UNDERSCORE)
                         || (c == llex_pkg::CH_LESS) || (c == llex_pkg::CH_SLASH))
                begin
                    tok_offset_next = cur_offset_reg;
                    tok_line_next   = cur_line_reg;
                    tok_column_next = cur_column_reg;
                    tok_length_next = LENGTH_BITS'(1);
                    if (is_digit)
                    begin
                        mode_next = M_INT;
                    end
                    else if (is_lower)
                    begin
                        mode_next = M_ATOM;
                        kp_next   = (c == llex_pkg::CH_LOWER_I) ? KP_I : KP_NO;
                    end
                    else if (c == llex_pkg::CH_LESS)
                    begin
                        mode_next = M_LT;
                    end
                    else if (c == llex_pkg::CH_SLASH)
                    begin
                        mode_next = M_SLASH;
                    end
                    else
                    begin
                        mode_next = M_VAR;
                        kp_next   = KP_NO;
                    end
                end
                else
                begin
                    fresh_vld      = 1'b1;
                    fresh_res.length = llex_pkg::LENGTH_W'(1);
                    case (c)
                        llex_pkg::CH_PLUS:   fresh_res.kind = llex_pkg::K_ADD;
                        llex_pkg::CH_STAR:   fresh_res.kind = llex_pkg::K_MUL;
                        llex_pkg::CH_LPAREN: fresh_res.kind = llex_pkg::K_LPAREN;
                        llex_pkg::CH_RPAREN: fresh_res.kind = llex_pkg::K_RPAREN;
                        llex_pkg::CH_COMMA:  fresh_res.kind = llex_pkg::K_COMMA;
                        llex_pkg::CH_DOT:    fresh_res.kind = llex_pkg::K_DOT;
                        llex_pkg::CH_EQUAL:  fresh_res.kind = llex_pkg::K_EQUAL;
                        default:
                        begin
                            fresh_res.kind   = llex_pkg::K_ERR;
                            fresh_res.length = '0;
                            mode_next        = M_ERROR;
                            do_advance       = 1'b0;
                        end
                    endcase
                end
            end
        end

        cur_offset_next = do_advance ? adv_offset : cur_offset_reg;
        cur_line_next   = do_advance ? adv_line   : cur_line_reg;
        cur_column_next = do_advance ? adv_column : cur_column_reg;

        if (src_data.end_req)
        begin
            mode_next       = M_IDLE;
            cur_offset_next = '0;
            cur_line_next   = LINE_BITS'(1);
            cur_column_next = COLUMN_BITS'(1);
            tok_offset_next = '0;
            tok_line_next   = LINE_BITS'(1);
            tok_column_next = COLUMN_BITS'(1);
            tok_length_next = '0;
            kp_next         = KP_NONE;
        end
    end

    always_comb
    begin
        r0      = pend_vld ? pend_res : fresh_res;
        r1      = fresh_res;
        r0.last = !(pend_vld && fresh_vld);
        r1.last = 1'b1;
        n_push  = take ? (2'(pend_vld) + 2'(fresh_vld)) : 2'd0;
    end

    always_comb
    begin
        head_next = pop ? head_reg + QPTR_W'(1) : head_reg;
        tail_next = tail_reg + QPTR_W'(n_push);
        cnt_next  = cnt_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            cur_offset_reg <= '0;
            cur_line_reg   <= LINE_BITS'(1);
            cur_column_reg <= COLUMN_BITS'(1);
            tok_offset_reg <= '0;
            tok_line_reg   <= LINE_BITS'(1);
            tok_column_reg <= COLUMN_BITS'(1);
            tok_length_reg <= '0;
            kp_reg         <= KP_NONE;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (take)
            begin
                mode_reg       <= mode_next;
                cur_offset_reg <= cur_offset_next;
                cur_line_reg   <= cur_line_next;
                cur_column_reg <= cur_column_next;
                tok_offset_reg <= tok_offset_next;
                tok_line_reg   <= tok_line_next;
                tok_column_reg <= tok_column_next;
                tok_length_reg <= tok_length_next;
                kp_reg         <= kp_next;
            end
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            q_reg[tail_reg] <= r0;
        end
        if (n_push == 2'd2)
        begin
            q_reg[tail_reg + QPTR_W'(1)] <= r1;
        end
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");

    a_room_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (cnt_reg <= QCNT_W'(QDEPTH - 2)))
        else $error("byte taken without room for two results");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && src_data.end_req) |=> (mode_reg == M_IDLE) && (cur_offset_reg == '0)
        && (cur_line_reg == LINE_BITS'(1)) && (cnt_reg != '0))
        else $error("end request did not restart scan or queue an end token");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !src_data.end_req && (mode_reg == M_ERROR)) |-> (n_push == 2'd0))
        else $error("result produced in error mode");
`endif

endmodule

[tb/lexer_token_checker.sv]
// Token checker for the logic language lexer: watches the request and token
// channels, predicts the tokens of every accepted request and compares them.
// Depends on llex_pkg for the request/token structs, widths and byte codes.
module lexer_token_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    input  logic                  src_stall,
    input  llex_pkg::src_item_t   src_data,
    input  logic                  tok_valid,
    input  logic                  tok_stall,
    input  llex_pkg::tok_item_t   tok_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output logic [13:0]           kinds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_VAR,
        SCAN_ATOM,
        SCAN_LESS,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_ERROR
    } scan_mode_t;

    typedef enum logic [1:0] {
        WORD_NONE,
        WORD_I,
        WORD_IS,
        WORD_OTHER
    } word_state_t;

    scan_mode_t                    mode;
    word_state_t                   word;
    logic [llex_pkg::OFFSET_W-1:0] pos_offset;
    logic [llex_pkg::LINE_W-1:0]   pos_line;
    logic [llex_pkg::COLUMN_W-1:0] pos_column;
    logic [llex_pkg::OFFSET_W-1:0] tok_offset;
    logic [llex_pkg::LINE_W-1:0]   tok_line;
    logic [llex_pkg::COLUMN_W-1:0] tok_column;
    logic [llex_pkg::LENGTH_W-1:0] tok_length;
    llex_pkg::tok_item_t           expected_tokens[$];

    function automatic logic is_space(logic [llex_pkg::CH_W-1:0] c);
        return c == llex_pkg::CH_SPACE || (c >= llex_pkg::CH_TAB && c <= llex_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(logic [llex_pkg::CH_W-1:0] c);
        return c >= llex_pkg::CH_DIGIT_0 && c <= llex_pkg::CH_DIGIT_9;
    endfunction

    function automatic logic is_upper(logic [llex_pkg::CH_W-1:0] c);
        return c >= llex_pkg::CH_UPPER_A && c <= llex_pkg::CH_UPPER_Z;
    endfunction

    function automatic logic is_lower(logic [llex_pkg::CH_W-1:0] c);
        return c >= llex_pkg::CH_LOWER_A && c <= llex_pkg::CH_LOWER_Z;
    endfunction

    function automatic void clear_scan();
        mode       = SCAN_IDLE;
        word       = WORD_NONE;
        pos_offset = '0;
        pos_line   = llex_pkg::LINE_W'(1);
        pos_column = llex_pkg::COLUMN_W'(1);
        tok_offset = '0;
        tok_line   = llex_pkg::LINE_W'(1);
        tok_column = llex_pkg::COLUMN_W'(1);
        tok_length = '0;
    endfunction

    function automatic void step_position(logic [llex_pkg::CH_W-1:0] c);
        if (pos_offset != '1)
            pos_offset++;
        if (c == llex_pkg::CH_NEWLINE)
        begin
            if (pos_line != '1)
                pos_line++;
            pos_column = llex_pkg::COLUMN_W'(1);
        end
        else if (pos_column != '1)
            pos_column++;
    endfunction

    function automatic void grow_token(logic [llex_pkg::CH_W-1:0] c);
        if (tok_length != '1)
            tok_length++;
        step_position(c);
    endfunction

    function automatic void open_token(scan_mode_t m, logic [llex_pkg::CH_W-1:0] c);
        mode       = m;
        tok_offset = pos_offset;
        tok_line   = pos_line;
        tok_column = pos_column;
        tok_length = llex_pkg::LENGTH_W'(1);
        step_position(c);
    endfunction

    function automatic void add_token(llex_pkg::kind_t k,
                                      logic [llex_pkg::OFFSET_W-1:0] off,
                                      logic [llex_pkg::LENGTH_W-1:0] len,
                                      logic [llex_pkg::LINE_W-1:0] ln,
                                      logic [llex_pkg::COLUMN_W-1:0] col);
        llex_pkg::tok_item_t t;
        t.kind         = k;
        t.start_offset = off;
        t.length       = len;
        t.line         = ln;
        t.column       = col;
        t.last         = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void add_pending();
        llex_pkg::kind_t k;
        if (mode == SCAN_INT)
            k = llex_pkg::K_INT;
        else if (mode == SCAN_VAR)
            k = llex_pkg::K_VAR;
        else if (word == WORD_IS)
            k = llex_pkg::K_IS;
        else
            k = llex_pkg::K_ATOM;
        add_token(k, tok_offset, tok_length, tok_line, tok_column);
    endfunction

    function automatic void scan_fresh(logic [llex_pkg::CH_W-1:0] c);
        llex_pkg::kind_t k;
        logic            sym;
        mode = SCAN_IDLE;
        if (is_space(c))
            step_position(c);
        else if (is_digit(c))
            open_token(SCAN_INT, c);
        else if (is_upper(c) || c == llex_pkg::CH_UNDERSCORE)
        begin
            word = WORD_OTHER;
            open_token(SCAN_VAR, c);
        end
        else if (is_lower(c))
        begin
            word = (c == llex_pkg::CH_LOWER_I) ? WORD_I : WORD_OTHER;
            open_token(SCAN_ATOM, c);
        end
        else if (c == llex_pkg::CH_LESS)
            open_token(SCAN_LESS, c);
        else if (c == llex_pkg::CH_SLASH)
            open_token(SCAN_SLASH, c);
        else
        begin
            sym = 1'b1;
            k   = llex_pkg::K_ADD;
            case (c)
                llex_pkg::CH_PLUS:   k = llex_pkg::K_ADD;
                llex_pkg::CH_STAR:   k = llex_pkg::K_MUL;
                llex_pkg::CH_LPAREN: k = llex_pkg::K_LPAREN;
                llex_pkg::CH_RPAREN: k = llex_pkg::K_RPAREN;
                llex_pkg::CH_COMMA:  k = llex_pkg::K_COMMA;
                llex_pkg::CH_DOT:    k = llex_pkg::K_DOT;
                llex_pkg::CH_EQUAL:  k = llex_pkg::K_EQUAL;
                default:             sym = 1'b0;
            endcase
            if (sym)
            begin
                add_token(k, pos_offset, llex_pkg::LENGTH_W'(1), pos_line, pos_column);
                step_position(c);
            end
            else
            begin
                add_token(llex_pkg::K_ERR, pos_offset, '0, pos_line, pos_column);
                mode = SCAN_ERROR;
            end
        end
    endfunction

    function automatic void predict_tokens(llex_pkg::src_item_t req);
        int                        first;
        logic [llex_pkg::CH_W-1:0] c;
        logic                      fresh;
        first = expected_tokens.size();
        c     = req.ch;
        fresh = 1'b0;
        if (req.end_req)
        begin
            case (mode)
                SCAN_INT, SCAN_VAR, SCAN_ATOM: add_pending();
                SCAN_LESS, SCAN_SLASH:
                    add_token(llex_pkg::K_ERR, tok_offset, '0, tok_line, tok_column);
                default: ;
            endcase
            add_token(llex_pkg::K_END, pos_offset, '0, pos_line, pos_column);
            clear_scan();
        end
        else
        begin
            case (mode)
                SCAN_ERROR: ;
                SCAN_COMMENT:
                begin
                    if (c == llex_pkg::CH_NEWLINE)
                        mode = SCAN_IDLE;
                    step_position(c);
                end
                SCAN_INT:
                begin
                    if (is_digit(c))
                        grow_token(c);
                    else
                    begin
                        add_pending();
                        fresh = 1'b1;
                    end
                end
                SCAN_VAR, SCAN_ATOM:
                begin
                    if (is_digit(c) || is_upper(c) || is_lower(c)
                        || c == llex_pkg::CH_UNDERSCORE)
                    begin
                        word = (word == WORD_I && c == llex_pkg::CH_LOWER_S)
                               ? WORD_IS : WORD_OTHER;
                        grow_token(c);
                    end
                    else
                    begin
                        add_pending();
                        fresh = 1'b1;
                    end
                end
                SCAN_LESS:
                begin
                    if (c == llex_pkg::CH_EQUAL)
                    begin
                        add_token(llex_pkg::K_LIMPLY, tok_offset, llex_pkg::LENGTH_W'(2),
                                  tok_line, tok_column);
                        step_position(c);
                        mode = SCAN_IDLE;
                    end
                    else
                    begin
                        add_token(llex_pkg::K_ERR, tok_offset, '0, tok_line, tok_column);
                        mode = SCAN_ERROR;
                    end
                end
                SCAN_SLASH:
                begin
                    if (c == llex_pkg::CH_SLASH)
                    begin
                        mode = SCAN_COMMENT;
                        step_position(c);
                    end
                    else
                    begin
                        add_token(llex_pkg::K_ERR, tok_offset, '0, tok_line, tok_column);
                        mode = SCAN_ERROR;
                    end
                end
                default: fresh = 1'b1;
            endcase
            if (fresh)
                scan_fresh(c);
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        llex_pkg::tok_item_t want;
        if (!rst_n)
        begin
            clear_scan();
            expected_tokens.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
            kinds_seen = '0;
        end
        else
        begin
            if (src_valid && !src_stall)
                predict_tokens(src_data);
            if (tok_valid && !tok_stall)
            begin
                if (tok_data.kind <= llex_pkg::K_ERR)
                    kinds_seen[tok_data.kind] = 1'b1;
                if (expected_tokens.size() == 0)
                begin
                    $error("token kind %0d at offset %0d arrived with nothing expected",
                           tok_data.kind, tok_data.start_offset);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    checked++;
                    if (tok_data.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, tok_data.kind);
                        fail_count++;
                    end
                    if (tok_data.start_offset !== want.start_offset)
                    begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start_offset, tok_data.start_offset);
                        fail_count++;
                    end
                    if (tok_data.length !== want.length)
                    begin
                        $error("length: expected %0d, got %0d", want.length, tok_data.length);
                        fail_count++;
                    end
                    if (tok_data.line !== want.line)
                    begin
                        $error("line: expected %0d, got %0d", want.line, tok_data.line);
                        fail_count++;
                    end
                    if (tok_data.column !== want.column)
                    begin
                        $error("column: expected %0d, got %0d", want.column, tok_data.column);
                        fail_count++;
                    end
                    if (tok_data.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, tok_data.last);
                        fail_count++;
                    end
                end
            end
            pending = expected_tokens.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the lexer testbench: clock, reset, source byte stimulus, token sink
// and verdict. Depends on llex_pkg, logic_language_lexer_top and
// lexer_token_checker, which does all prediction and comparison.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1800;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    llex_pkg::src_item_t src_data;
    logic                tok_valid;
    logic                tok_stall;
    llex_pkg::tok_item_t tok_data;
    int                  fail_count;
    int                  pending;
    int                  checked;
    logic [13:0]         kinds_seen;

    logic src_idle  = 1'b1;
    logic sink_idle = 1'b1;
    logic hold_req  = 1'b0;
    int   bytes_sent   = 0;
    int   random_bytes = 0;
    int   programs     = 0;
    int   cycle_count  = 0;

    logic_language_lexer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    lexer_token_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_data   (tok_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .kinds_seen (kinds_seen)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stall the token side per accepted token, or hold it off on request
    initial
    begin : token_sink
        int stall_left;
        stall_left = 0;
        tok_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                tok_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                tok_stall  <= 1'b0;
                hold_req   = 1'b0;
                stall_left = 0;
            end
            else
            begin
                if (tok_valid && !tok_stall)
                    stall_left = sink_idle ? $urandom_range(0, 19) : 0;
                else if (stall_left > 0)
                    stall_left--;
                tok_stall <= (stall_left > 0);
            end
        end
    end

    task automatic send_req(input logic [llex_pkg::CH_W-1:0] c, input logic e);
        int gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= '{ch: c, end_req: e};
        do
            @(posedge clk);
        while (src_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_req(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // drop valid and wait until every predicted token has been taken
    task automatic drain_tokens();
        src_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [llex_pkg::CH_W-1:0] ident_char();
        int sel;
        sel = $urandom_range(0, 62);
        if (sel < 10)
            return 8'(llex_pkg::CH_DIGIT_0 + sel);
        else if (sel < 36)
            return 8'(llex_pkg::CH_UPPER_A + sel - 10);
        else if (sel < 62)
            return 8'(llex_pkg::CH_LOWER_A + sel - 36);
        return llex_pkg::CH_UNDERSCORE;
    endfunction

    // one source program: well-formed lexemes, mostly, then an end request
    task automatic send_program();
        int                        lexemes;
        int                        pick;
        int                        sel;
        logic                      broken;
        logic [llex_pkg::CH_W-1:0] b;
        logic [llex_pkg::CH_W-1:0] text[$];
        lexemes = $urandom_range(1, 12);
        broken  = 1'b0;
        for (int i = 0; i < lexemes && !broken; i++)
        begin
            text.delete();
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                repeat ($urandom_range(1, 5))
                    text.push_back(8'(llex_pkg::CH_DIGIT_0 + $urandom_range(0, 9)));
            end
            else if (pick < 28)
            begin
                text.push_back(8'(llex_pkg::CH_LOWER_A + $urandom_range(0, 25)));
                repeat ($urandom_range(0, 5)) text.push_back(ident_char());
            end
            else if (pick < 32)
            begin
                text.push_back(llex_pkg::CH_LOWER_I);
                if ($urandom_range(0, 2) != 0)
                    text.push_back(llex_pkg::CH_LOWER_S);
                if ($urandom_range(0, 2) == 0)
                    text.push_back(ident_char());
            end
            else if (pick < 42)
            begin
                if ($urandom_range(0, 3) == 0)
                    text.push_back(llex_pkg::CH_UNDERSCORE);
                else
                    text.push_back(8'(llex_pkg::CH_UPPER_A + $urandom_range(0, 25)));
                repeat ($urandom_range(0, 5)) text.push_back(ident_char());
            end
            else if (pick < 58)
            begin
                sel = $urandom_range(0, 7);
                case (sel)
                    0: text.push_back(llex_pkg::CH_PLUS);
                    1: text.push_back(llex_pkg::CH_STAR);
                    2: text.push_back(llex_pkg::CH_LPAREN);
                    3: text.push_back(llex_pkg::CH_RPAREN);
                    4: text.push_back(llex_pkg::CH_COMMA);
                    5: text.push_back(llex_pkg::CH_DOT);
                    6: text.push_back(llex_pkg::CH_EQUAL);
                    default:
                    begin
                        text.push_back(llex_pkg::CH_LESS);
                        text.push_back(llex_pkg::CH_EQUAL);
                    end
                endcase
            end
            else if (pick < 72)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    sel = $urandom_range(0, 7);
                    if (sel < 5)
                        text.push_back(8'(llex_pkg::CH_TAB + sel));
                    else if (sel == 5)
                        text.push_back(llex_pkg::CH_NEWLINE);
                    else
                        text.push_back(llex_pkg::CH_SPACE);
                end
            end
            else if (pick < 80)
            begin
                text.push_back(llex_pkg::CH_SLASH);
                text.push_back(llex_pkg::CH_SLASH);
                repeat ($urandom_range(0, 6))
                begin
                    b = 8'($urandom_range(0, 255));
                    text.push_back(b == llex_pkg::CH_NEWLINE ? llex_pkg::CH_SPACE : b);
                end
                if ($urandom_range(0, 3) != 0)
                    text.push_back(llex_pkg::CH_NEWLINE);
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
                broken = 1'b1;
            end
            else
            begin
                text.push_back($urandom_range(0, 1) ? llex_pkg::CH_LESS : llex_pkg::CH_SLASH);
                text.push_back(8'($urandom_range(0, 255)));
                broken = 1'b1;
            end
            if (!broken && $urandom_range(0, 1) == 0)
                text.push_back(llex_pkg::CH_SPACE);
            foreach (text[j])
            begin
                send_req(text[j], 1'b0);
                random_bytes++;
            end
        end
        if (broken)
            repeat ($urandom_range(0, 2)) send_req(8'($urandom_range(0, 255)), 1'b0);
        send_end();
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("+*(),.=<=is i_Z 12x//c");
        send_end();
        send_text("<q");
        send_end();
        send_text("/+");
        send_end();
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_end();
        send_text("x<");
        send_end();
        send_text("Q9");
        send_end();
        drain_tokens();

        // hold off the sink while the source keeps streaming
        src_idle = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_text("+(");
        send_end();
        drain_tokens();

        while (random_bytes < RANDOM_BYTES)
        begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            send_program();
            programs++;
        end

        drain_tokens();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("%0d expected tokens never arrived", pending);
        $display("Lexed %0d source bytes: directed cases, a sink hold, %0d random programs",
                 bytes_sent, programs);
        $display("with random gaps on both sides; %0d tokens checked, %0d of 14 kinds seen.",
                 checked, $countones(kinds_seen));
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
